// ----- rtl/linear_probe_hash_set_assert.svh -----
// Assertion macros used by the hash set top level.
`ifndef LINEAR_PROBE_HASH_SET_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LPHS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("linear_probe_hash_set: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LPHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("linear_probe_hash_set: assertion failed");

`endif

// ----- rtl/lphs_pkg.sv -----
// Shared constants, codes and types of the linear-probing hash set.
package lphs_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 97;
  localparam int KEY_BITS    = 31;
  localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
  localparam int COUNT_BITS  = $clog2(TABLE_SLOTS + 1);

  // Reciprocal for key mod TABLE_SLOTS: quotient estimate is low by at most one
  localparam int RECIP_SHIFT = KEY_BITS + SLOT_BITS;
  localparam int RECIP_BITS  = KEY_BITS + 1;
  localparam int PROD_BITS   = KEY_BITS + RECIP_BITS;
  localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;
  localparam int REM_BITS    = SLOT_BITS + 1;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'((64'd1 << RECIP_SHIFT) / TABLE_SLOTS);

  // Operation codes (code 3 behaves as a lookup)
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NEG_KEY   = 2'd3;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_t;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [KEY_BITS-1:0]  key_t;

  typedef struct packed {
    mark_t mark;
    key_t  key;
  } entry_t;

  typedef struct packed {
    logic  en;
    slot_t addr;
  } rd_req_t;

  typedef struct packed {
    logic   en;
    slot_t  addr;
    entry_t data;
  } wr_req_t;

endpackage

// ----- rtl/linear_probe_hash_set.sv -----
// Top level of the linear-probing hash set: probe sequencer and result register.
// Open-addressing hash set of 97 slots with linear probing and tombstones. Each
// input beat carries an operation (insert, erase, lookup) and a signed key; each
// gives exactly one result beat with a status, a lookup hit flag and the number
// of occupied slots. Items are handled one at a time: the home slot comes from
// the hash unit, then the probe walks one slot per cycle, bounded by the single
// read port of the slot memory, over at most 97 slots; the result is loaded into
// the output register once that register is free, and the next item can then be
// accepted. A negative key is rejected without touching the table. The input
// stalls while an item is in flight and during reset; a finished result waits
// in the output register while the next item is accepted.
`include "linear_probe_hash_set_assert.svh"

module linear_probe_hash_set (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic signed [31:0] key,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               present,
  output logic [6:0]         entry_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_EMIT
  } state_t;

  state_t                             state;
  logic [1:0]                         op_r;
  lphs_pkg::key_t                     key_r;
  lphs_pkg::slot_t                    slot;
  lphs_pkg::slot_t                    probe_n;
  logic [lphs_pkg::COUNT_BITS-1:0]    count;
  logic [lphs_pkg::COUNT_BITS-1:0]    count_next;
  logic [lphs_pkg::COUNT_BITS-1:0]    out_count;
  logic [1:0]                         res_status;
  logic                               res_present;

  logic                               hash_start;
  logic                               hash_done;
  lphs_pkg::slot_t                    hash_slot;
  lphs_pkg::rd_req_t                  rd;
  lphs_pkg::wr_req_t                  wr;
  lphs_pkg::entry_t                   entry;

  logic                               is_insert;
  logic                               is_erase;
  logic                               match;
  logic                               stop_here;
  logic                               last_probe;
  lphs_pkg::slot_t                    slot_next;
  logic [1:0]                         probe_status;
  logic                               probe_present;

  assign in_stall    = rst || (state != S_IDLE);
  assign hash_start  = (state == S_IDLE) && in_valid && !key[31];
  assign entry_count = 7'(out_count);

  lphs_hash u_hash (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key_in (key[lphs_pkg::KEY_BITS-1:0]),
    .done   (hash_done),
    .slot   (hash_slot)
  );

  lphs_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .wr      (wr),
    .rd_data (entry)
  );

  // Probe decision on the entry read for the current slot
  always_comb begin
    is_insert  = (op_r == lphs_pkg::OP_INSERT);
    is_erase   = (op_r == lphs_pkg::OP_ERASE);
    match      = (entry.mark == lphs_pkg::MARK_USED) && (entry.key == key_r);
    last_probe = (probe_n == lphs_pkg::SLOT_BITS'(lphs_pkg::TABLE_SLOTS - 1));
    slot_next  = (slot == lphs_pkg::SLOT_BITS'(lphs_pkg::TABLE_SLOTS - 1)) ?
                 '0 : slot + 1'b1;
    if (is_insert) begin
      stop_here = (entry.mark != lphs_pkg::MARK_USED);
    end else begin
      stop_here = (entry.mark == lphs_pkg::MARK_EMPTY) || match;
    end

    // Result when the walk ends here (or the pass is complete)
    probe_present = 1'b0;
    if (is_insert) begin
      probe_status = stop_here ? lphs_pkg::ST_DONE : lphs_pkg::ST_FULL;
    end else if (match) begin
      probe_status  = lphs_pkg::ST_DONE;
      probe_present = !is_erase;
    end else begin
      probe_status = lphs_pkg::ST_NOT_FOUND;
    end

    // Occupancy after a terminating probe
    count_next = count;
    if (stop_here && is_insert) begin
      count_next = count + 1'b1;
    end else if (stop_here && is_erase && match && (count != '0)) begin
      count_next = count - 1'b1;
    end
  end

  // Memory requests: prefetch the next slot while checking this one
  always_comb begin
    rd.en   = 1'b0;
    rd.addr = slot_next;
    wr.en   = 1'b0;
    wr.addr = slot;
    wr.data = '{mark: lphs_pkg::MARK_USED, key: key_r};
    unique case (state)
      S_HASH: begin
        rd.en   = hash_done;
        rd.addr = hash_slot;
      end
      S_PROBE: begin
        rd.en = !stop_here && !last_probe;
        if (stop_here && is_insert) begin
          wr.en = 1'b1;
        end else if (stop_here && is_erase && match) begin
          wr.en   = 1'b1;
          wr.data = '{mark: lphs_pkg::MARK_GONE, key: entry.key};
        end
      end
      default: begin
        rd.en = 1'b0;
      end
    endcase
  end

  // Sequencer, occupancy count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      // a beat taken while a new result is loaded is refilled below
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= op;
            key_r <= key[lphs_pkg::KEY_BITS-1:0];
            if (key[31]) begin
              res_status  <= lphs_pkg::ST_NEG_KEY;
              res_present <= 1'b0;
              state       <= S_EMIT;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot    <= hash_slot;
            probe_n <= '0;
            state   <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (stop_here || last_probe) begin
            res_status  <= probe_status;
            res_present <= probe_present;
            count       <= count_next;
            state       <= S_EMIT;
          end else begin
            slot    <= slot_next;
            probe_n <= probe_n + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status    <= res_status;
            present   <= res_present;
            out_count <= count;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Checks
  `LPHS_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= lphs_pkg::COUNT_BITS'(lphs_pkg::TABLE_SLOTS))
  `LPHS_ASSERT_IMPL(a_slot_range, clk, rst, state == S_PROBE, slot < lphs_pkg::SLOT_BITS'(lphs_pkg::TABLE_SLOTS))
  `LPHS_ASSERT_NEXT(a_write_ends_walk, clk, rst, wr.en, state == S_EMIT)
  `LPHS_ASSERT_IMPL(a_hit_is_done, clk, rst, out_valid && present, status == lphs_pkg::ST_DONE)
  `LPHS_ASSERT_IMPL(a_hash_only_hashing, clk, rst, hash_done, state == S_HASH)

endmodule

// ----- rtl/lphs_hash.sv -----
// Three-stage home-slot unit: key modulo TABLE_SLOTS by reciprocal multiply.
module lphs_hash (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lphs_pkg::key_t       key_in,
  output logic                 done,
  output lphs_pkg::slot_t      slot
);

  logic                               v1;
  logic                               v2;
  logic [lphs_pkg::PROD_BITS-1:0]     prod;
  lphs_pkg::key_t                     key1;
  logic [lphs_pkg::REM_BITS-1:0]      rem;
  logic [lphs_pkg::QUOT_BITS-1:0]     quot;
  lphs_pkg::key_t                     quot_mul;

  // Quotient estimate and its multiple of the table size
  assign quot     = prod[lphs_pkg::PROD_BITS-1:lphs_pkg::RECIP_SHIFT];
  assign quot_mul = lphs_pkg::KEY_BITS'(quot) * lphs_pkg::KEY_BITS'(lphs_pkg::TABLE_SLOTS);

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // Datapath: multiply, subtract, one correction step
  always_ff @(posedge clk) begin
    prod <= lphs_pkg::PROD_BITS'(key_in) * lphs_pkg::PROD_BITS'(lphs_pkg::RECIP);
    key1 <= key_in;
    // true remainder is below twice the table size, so the low bits suffice
    rem  <= lphs_pkg::REM_BITS'(key1 - quot_mul);
    if (rem >= lphs_pkg::REM_BITS'(lphs_pkg::TABLE_SLOTS)) begin
      slot <= lphs_pkg::SLOT_BITS'(rem - lphs_pkg::REM_BITS'(lphs_pkg::TABLE_SLOTS));
    end else begin
      slot <= lphs_pkg::SLOT_BITS'(rem);
    end
  end

endmodule

// ----- rtl/lphs_table.sv -----
// Slot memory: key and mark per slot, one read and one write port, fill bits.
module lphs_table (
  input  logic                clk,
  input  logic                rst,
  input  lphs_pkg::rd_req_t   rd,
  input  lphs_pkg::wr_req_t   wr,
  output lphs_pkg::entry_t    rd_data
);

  lphs_pkg::entry_t                  mem [lphs_pkg::TABLE_SLOTS];
  logic [lphs_pkg::TABLE_SLOTS-1:0]  filled;
  lphs_pkg::entry_t                  rd_word;
  logic                              rd_filled;

  // Synchronous write, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_word   <= mem[rd.addr];
      rd_filled <= filled[rd.addr];
    end
  end

  // A slot never written reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr.en) begin
      filled[wr.addr] <= 1'b1;
    end
  end

  always_comb begin
    rd_data = rd_word;
    if (!rd_filled) begin
      rd_data.mark = lphs_pkg::MARK_EMPTY;
    end
  end

endmodule
